[rtl/mmss_countdown_clock_display_defines.svh]
// Assertion macros shared by the countdown clock RTL.
`ifndef MMSS_COUNTDOWN_CLOCK_DISPLAY_DEFINES_SVH
`define MMSS_COUNTDOWN_CLOCK_DISPLAY_DEFINES_SVH

// Clocked check, switched off while the synchronous reset is asserted.
`define MMSS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that is also evaluated during reset.
`define MMSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mmss_pkg.sv]
// Types, codes and constants shared by the countdown clock modules.
package mmss_pkg;

    localparam int MIN_W   = 7;
    localparam int SEC_W   = 6;
    localparam int PRE_W   = 16;
    localparam int SEG_W   = 7;
    localparam int OP_W    = 3;
    localparam int AMT_W   = 7;
    localparam int DIGIT_W = 4;

    // Request opcodes; the last code changes nothing.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_MINUS = 3'd2;
    localparam logic [OP_W-1:0] OP_SET   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET = 3'd4;
    localparam logic [OP_W-1:0] OP_PLAY  = 3'd5;
    localparam logic [OP_W-1:0] OP_PAUSE = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd7;

    // Register indexes, taken from address bit 2.
    localparam logic REG_SECOND_PERIOD = 1'b0;
    localparam logic REG_BLINK_HALF    = 1'b1;

    localparam logic [MIN_W-1:0] MAX_MINUTES  = 7'd99;
    localparam logic [SEC_W-1:0] MAX_SECONDS  = 6'd59;
    localparam logic [PRE_W-1:0] PRESCALE_MAX = 16'hFFFF;

    localparam logic [PRE_W-1:0] SECOND_PERIOD_RST = 16'd1000;
    localparam logic [PRE_W-1:0] BLINK_HALF_RST    = 16'd500;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Clock state after one request, passed from the core to the decoder.
    typedef struct packed {
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic             lit;
        logic             running;
        logic             expired;
    } t_view;

    typedef struct packed {
        logic [SEG_W-1:0] min_tens;
        logic [SEG_W-1:0] min_units;
        logic [SEG_W-1:0] sec_tens;
        logic [SEG_W-1:0] sec_units;
    } t_segments;

endpackage

[rtl/mmss_core.sv]
// Countdown state registers and the update applied for each request.
module mmss_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [mmss_pkg::OP_W-1:0]     i_opcode,
    input  logic [mmss_pkg::AMT_W-1:0]    i_amount,
    input  logic [mmss_pkg::PRE_W-1:0]    i_second_period,
    input  logic [mmss_pkg::PRE_W-1:0]    i_blink_half,
    output mmss_pkg::t_view               o_view
);
    import mmss_pkg::*;

    logic [MIN_W-1:0] r_min, n_min;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic             r_run, n_run;
    logic             r_lit, n_lit;
    logic [PRE_W-1:0] r_sp, n_sp;
    logic [PRE_W-1:0] r_bp, n_bp;
    logic             n_exp;
    logic [PRE_W-1:0] sp_inc, bp_inc;
    logic [MIN_W:0]   min_sum;

    assign sp_inc  = (r_sp == PRESCALE_MAX) ? r_sp : r_sp + 1'b1;
    assign bp_inc  = (r_bp == PRESCALE_MAX) ? r_bp : r_bp + 1'b1;
    assign min_sum = {1'b0, r_min} + {1'b0, i_amount};

    always_comb begin
        n_min = r_min;
        n_sec = r_sec;
        n_run = r_run;
        n_lit = r_lit;
        n_sp  = r_sp;
        n_bp  = r_bp;
        n_exp = 1'b0;
        case (i_opcode)
            OP_TICK: begin
                n_sp = sp_inc;
                n_bp = bp_inc;
                if (r_run) begin
                    n_lit = 1'b1;
                    if (sp_inc >= i_second_period) begin
                        n_sp = '0;
                        if (r_sec == '0) begin
                            if (r_min != '0) begin
                                n_min = r_min - 1'b1;
                                n_sec = MAX_SECONDS;
                            end else begin
                                n_run = 1'b0;
                                n_exp = 1'b1;
                            end
                        end else begin
                            n_sec = r_sec - 1'b1;
                        end
                    end
                end else if (r_min != '0 || r_sec != '0) begin
                    if (bp_inc >= i_blink_half) begin
                        n_bp  = '0;
                        n_lit = ~r_lit;
                    end
                end else begin
                    n_lit = 1'b1;
                end
            end
            OP_ADD: begin
                n_min = (min_sum > {1'b0, MAX_MINUTES}) ? MAX_MINUTES : min_sum[MIN_W-1:0];
                n_lit = 1'b1;
            end
            OP_MINUS: begin
                if (r_min != '0) begin
                    n_min = r_min - 1'b1;
                end
                n_lit = 1'b1;
            end
            OP_SET: begin
                if (i_amount <= MAX_MINUTES) begin
                    n_min = i_amount;
                    n_sec = '0;
                    n_lit = 1'b1;
                end
            end
            OP_RESET: begin
                n_min = '0;
                n_sec = '0;
                n_run = 1'b0;
                n_lit = 1'b1;
            end
            OP_PLAY: begin
                n_run = 1'b1;
                n_lit = 1'b1;
            end
            OP_PAUSE: begin
                n_run = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_sec <= '0;
            r_run <= 1'b0;
            r_lit <= 1'b1;
            r_sp  <= '0;
            r_bp  <= '0;
        end else if (i_step) begin
            r_min <= n_min;
            r_sec <= n_sec;
            r_run <= n_run;
            r_lit <= n_lit;
            r_sp  <= n_sp;
            r_bp  <= n_bp;
        end
    end

    assign o_view = '{minutes: n_min, seconds: n_sec, lit: n_lit,
                      running: n_run, expired: n_exp};

endmodule

[rtl/mmss_seg.sv]
// Splits minutes and seconds into decimal digits and maps them to segments.
module mmss_seg (
    input  mmss_pkg::t_view     i_view,
    output mmss_pkg::t_segments o_segs
);
    import mmss_pkg::*;

    // Tens digit by reciprocal multiply, exact for every 7-bit input (0 to 127).
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [MIN_W-1:0] v);
        logic [MIN_W+7:0] prod;
        prod = {8'd0, v} * (MIN_W+8)'(205);
        return prod[MIN_W+7:11];
    endfunction

    function automatic logic [DIGIT_W-1:0] units_of(input logic [MIN_W-1:0] v,
                                                    input logic [DIGIT_W-1:0] t);
        logic [MIN_W-1:0] rest;
        rest = v - MIN_W'(t) * MIN_W'(10);
        return rest[DIGIT_W-1:0];
    endfunction

    logic [DIGIT_W-1:0] m_t, m_u, s_t, s_u;
    logic [MIN_W-1:0]   sec_wide;

    assign sec_wide = {1'b0, i_view.seconds};
    assign m_t = tens_of(i_view.minutes);
    assign m_u = units_of(i_view.minutes, m_t);
    assign s_t = tens_of(sec_wide);
    assign s_u = units_of(sec_wide, s_t);

    always_comb begin
        if (i_view.lit) begin
            o_segs.min_tens  = SEG_TABLE[m_t];
            o_segs.min_units = SEG_TABLE[m_u];
            o_segs.sec_tens  = SEG_TABLE[s_t];
            o_segs.sec_units = SEG_TABLE[s_u];
        end else begin
            o_segs = '0;
        end
    end

endmodule

[rtl/mmss_countdown_clock_display.sv]
// Top level of the MM:SS countdown clock with four seven-segment digit outputs.
// A request is captured in an input register, updated and decoded in one pass, and
// its result moves into the output register once that register is free. One request
// per cycle is sustained unless results stall; update and decode are combinational.
// Synchronous active-low reset clears the time, stops the clock, lights the display,
// zeroes both prescalers and restores the period registers to 1000 and 500.
`include "mmss_countdown_clock_display_defines.svh"

module mmss_countdown_clock_display (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mmss_pkg::OP_W-1:0]    i_opcode,
    input  logic [mmss_pkg::AMT_W-1:0]   i_amount,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mmss_pkg::SEG_W-1:0]   o_min_tens_segments,
    output logic [mmss_pkg::SEG_W-1:0]   o_min_units_segments,
    output logic [mmss_pkg::SEG_W-1:0]   o_sec_tens_segments,
    output logic [mmss_pkg::SEG_W-1:0]   o_sec_units_segments,
    output logic                         o_display_lit,
    output logic                         o_is_running,
    output logic                         o_expired,
    output logic [mmss_pkg::MIN_W-1:0]   o_minutes_now,
    output logic [mmss_pkg::SEC_W-1:0]   o_seconds_now,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mmss_pkg::*;

    logic [PRE_W-1:0] r_second_period;
    logic [PRE_W-1:0] r_blink_half;

    logic             r_in_vld;
    logic [OP_W-1:0]  r_in_op;
    logic [AMT_W-1:0] r_in_amt;

    logic             r_out_vld;
    t_view            r_out_view;
    t_segments        r_out_segs;

    logic             out_free;
    logic             advance;
    logic             in_take;
    t_view            view;
    t_segments        segs;

    // Configuration registers. Only address bit 2 selects the register, so every
    // write lands in one of the two.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_period <= SECOND_PERIOD_RST;
            r_blink_half    <= BLINK_HALF_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_SECOND_PERIOD: r_second_period <= pwdata[PRE_W-1:0];
                REG_BLINK_HALF:    r_blink_half    <= pwdata[PRE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SECOND_PERIOD: prdata = {{(32-PRE_W){1'b0}}, r_second_period};
            REG_BLINK_HALF:    prdata = {{(32-PRE_W){1'b0}}, r_blink_half};
            default:           prdata = '0;
        endcase
    end

    // The held request moves on whenever the output register is empty or its
    // contents are being taken this cycle. A new request is taken whenever the input
    // register is empty or its request moves on; otherwise the request side stalls.
    assign out_free = !r_out_vld || !i_stall;
    assign advance  = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= i_opcode;
            r_in_amt <= i_amount;
        end
    end

    // The core commits its state only when the request moves into the output
    // register, so the state always matches the last result placed in that register.
    mmss_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_opcode        (r_in_op),
        .i_amount        (r_in_amt),
        .i_second_period (r_second_period),
        .i_blink_half    (r_blink_half),
        .o_view          (view)
    );

    mmss_seg u_seg (
        .i_view (view),
        .o_segs (segs)
    );

    // Output register; while the result is stalled it does not change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_view <= view;
            r_out_segs <= segs;
        end
    end

    assign o_valid              = r_out_vld;
    assign o_min_tens_segments  = r_out_segs.min_tens;
    assign o_min_units_segments = r_out_segs.min_units;
    assign o_sec_tens_segments  = r_out_segs.sec_tens;
    assign o_sec_units_segments = r_out_segs.sec_units;
    assign o_display_lit        = r_out_view.lit;
    assign o_is_running         = r_out_view.running;
    assign o_expired            = r_out_view.expired;
    assign o_minutes_now        = r_out_view.minutes;
    assign o_seconds_now        = r_out_view.seconds;

    // A countdown that has just expired has also stopped.
    `MMSS_ASSERT_CLK(a_expired_stops, i_clk, i_rst_n, r_out_vld |-> !(r_out_view.expired && r_out_view.running), "expired result still shows the clock running")
    // A blanked display carries no segments.
    `MMSS_ASSERT_CLK(a_blank_dark, i_clk, i_rst_n, (r_out_vld && !r_out_view.lit) |-> (r_out_segs == '0), "segments driven while display blanked")
    // Time stays within its decimal ranges.
    `MMSS_ASSERT_CLK(a_time_range, i_clk, i_rst_n, r_out_vld |-> (r_out_view.minutes <= MAX_MINUTES && r_out_view.seconds <= MAX_SECONDS), "time out of range")
    // The request side is only held off while a request is waiting inside.
    `MMSS_ASSERT_ALWAYS(a_stall_cause, i_clk, o_stall |-> r_in_vld, "input stalled with no request held")

endmodule

[verif/mmss_countdown_checker.sv]
// Checker for the countdown clock: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps

module mmss_countdown_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_stall,
    input  logic [mmss_pkg::OP_W-1:0]  i_opcode,
    input  logic [mmss_pkg::AMT_W-1:0] i_amount,
    input  logic                       i_res_valid,
    input  logic                       i_res_stall,
    input  logic [mmss_pkg::SEG_W-1:0] i_min_tens_segments,
    input  logic [mmss_pkg::SEG_W-1:0] i_min_units_segments,
    input  logic [mmss_pkg::SEG_W-1:0] i_sec_tens_segments,
    input  logic [mmss_pkg::SEG_W-1:0] i_sec_units_segments,
    input  logic                       i_display_lit,
    input  logic                       i_is_running,
    input  logic                       i_expired,
    input  logic [mmss_pkg::MIN_W-1:0] i_minutes_now,
    input  logic [mmss_pkg::SEC_W-1:0] i_seconds_now,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import mmss_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0] min_tens;
        logic [SEG_W-1:0] min_units;
        logic [SEG_W-1:0] sec_tens;
        logic [SEG_W-1:0] sec_units;
        logic             lit;
        logic             running;
        logic             expired;
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
    } t_clock_face;

    // Predicted clock state and register copies.
    logic [MIN_W-1:0] face_min;
    logic [SEC_W-1:0] face_sec;
    logic             run_on;
    logic             lit_on;
    logic [PRE_W-1:0] sec_count;
    logic [PRE_W-1:0] blink_count;
    logic [PRE_W-1:0] sec_period;
    logic [PRE_W-1:0] blink_half;

    t_clock_face pending_faces[$];
    int          n_failures = 0;
    int          n_faces = 0;

    assign o_fail_count = n_failures;
    assign o_pending    = n_faces;

    function automatic logic [SEG_W-1:0] seg_pattern(input int digit);
        case (digit)
            0: return 7'h3F;
            1: return 7'h06;
            2: return 7'h5B;
            3: return 7'h4F;
            4: return 7'h66;
            5: return 7'h6D;
            6: return 7'h7D;
            7: return 7'h07;
            8: return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    function automatic logic [PRE_W-1:0] count_up(input logic [PRE_W-1:0] v);
        return (v == PRESCALE_MAX) ? v : v + 1'b1;
    endfunction

    // Applies one request to the predicted clock and queues the face it shows.
    task automatic advance_clock(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt);
        t_clock_face face;
        logic        ended;
        int          sum;
        ended = 1'b0;
        case (op)
            OP_TICK: begin
                sec_count   = count_up(sec_count);
                blink_count = count_up(blink_count);
                if (run_on) begin
                    lit_on = 1'b1;
                    if (sec_count >= sec_period) begin
                        sec_count = '0;
                        if (face_sec == 0) begin
                            if (face_min > 0) begin
                                face_min = face_min - 1'b1;
                                face_sec = MAX_SECONDS;
                            end else begin
                                run_on = 1'b0;
                                ended  = 1'b1;
                            end
                        end else begin
                            face_sec = face_sec - 1'b1;
                        end
                    end
                end else if (face_min != 0 || face_sec != 0) begin
                    if (blink_count >= blink_half) begin
                        blink_count = '0;
                        lit_on      = ~lit_on;
                    end
                end else begin
                    lit_on = 1'b1;
                end
            end
            OP_ADD: begin
                sum      = int'(face_min) + int'(amt);
                face_min = (sum > int'(MAX_MINUTES)) ? MAX_MINUTES : sum[MIN_W-1:0];
                lit_on   = 1'b1;
            end
            OP_MINUS: begin
                if (face_min > 0) face_min = face_min - 1'b1;
                lit_on = 1'b1;
            end
            OP_SET: begin
                if (amt <= MAX_MINUTES) begin
                    face_min = amt;
                    face_sec = '0;
                    lit_on   = 1'b1;
                end
            end
            OP_RESET: begin
                face_min = '0;
                face_sec = '0;
                run_on   = 1'b0;
                lit_on   = 1'b1;
            end
            OP_PLAY: begin
                run_on = 1'b1;
                lit_on = 1'b1;
            end
            OP_PAUSE: begin
                run_on = 1'b0;
            end
            default: begin
            end
        endcase

        face.min_tens  = lit_on ? seg_pattern(int'(face_min) / 10) : '0;
        face.min_units = lit_on ? seg_pattern(int'(face_min) % 10) : '0;
        face.sec_tens  = lit_on ? seg_pattern(int'(face_sec) / 10) : '0;
        face.sec_units = lit_on ? seg_pattern(int'(face_sec) % 10) : '0;
        face.lit       = lit_on;
        face.running   = run_on;
        face.expired   = ended;
        face.minutes   = face_min;
        face.seconds   = face_sec;
        pending_faces.push_back(face);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_face();
        t_clock_face want;
        if (pending_faces.size() == 0) begin
            n_failures++;
            $display("%0t: result with nothing expected, minutes %0d seconds %0d",
                     $time, i_minutes_now, i_seconds_now);
            return;
        end
        want = pending_faces.pop_front();
        check_field("min_tens_segments", int'(want.min_tens), int'(i_min_tens_segments));
        check_field("min_units_segments", int'(want.min_units), int'(i_min_units_segments));
        check_field("sec_tens_segments", int'(want.sec_tens), int'(i_sec_tens_segments));
        check_field("sec_units_segments", int'(want.sec_units), int'(i_sec_units_segments));
        check_field("display_lit", int'(want.lit), int'(i_display_lit));
        check_field("is_running", int'(want.running), int'(i_is_running));
        check_field("expired", int'(want.expired), int'(i_expired));
        check_field("minutes_now", int'(want.minutes), int'(i_minutes_now));
        check_field("seconds_now", int'(want.seconds), int'(i_seconds_now));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            face_min    = '0;
            face_sec    = '0;
            run_on      = 1'b0;
            lit_on      = 1'b1;
            sec_count   = '0;
            blink_count = '0;
            sec_period  = SECOND_PERIOD_RST;
            blink_half  = BLINK_HALF_RST;
            pending_faces.delete();
        end else begin
            // Results leave before this edge's request is predicted, so a result
            // can never be matched against a request accepted at the same edge.
            if (i_res_valid && !i_res_stall) compare_face();
            if (i_req_valid && !i_req_stall) advance_clock(i_opcode, i_amount);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SECOND_PERIOD) sec_period = pwdata[PRE_W-1:0];
                else blink_half = pwdata[PRE_W-1:0];
            end
        end
        n_faces = pending_faces.size();
    end

endmodule

[verif/tb_mmss_countdown_clock_display.sv]
// Testbench top for the countdown clock: drives requests and register writes, gives the verdict.
`timescale 1ns / 100ps

module tb_mmss_countdown_clock_display;
    import mmss_pkg::*;

    // The whole run is far shorter than this; it only catches a hung handshake.
    localparam int RUN_LIMIT_NS = 20_000_000;
    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES  = 80;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [OP_W-1:0]  i_opcode;
    logic [AMT_W-1:0] i_amount;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [SEG_W-1:0] o_min_tens_segments;
    logic [SEG_W-1:0] o_min_units_segments;
    logic [SEG_W-1:0] o_sec_tens_segments;
    logic [SEG_W-1:0] o_sec_units_segments;
    logic             o_display_lit;
    logic             o_is_running;
    logic             o_expired;
    logic [MIN_W-1:0] o_minutes_now;
    logic [SEC_W-1:0] o_seconds_now;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int fail_count;
    int faces_pending;

    // Idle percentages for each side, changed between phases by the main sequence.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_sent = 0;

    // The main sequence bumps hold_reqs to ask the receiver for one long hold-off.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mmss_countdown_clock_display DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_opcode             (i_opcode),
        .i_amount             (i_amount),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_min_tens_segments  (o_min_tens_segments),
        .o_min_units_segments (o_min_units_segments),
        .o_sec_tens_segments  (o_sec_tens_segments),
        .o_sec_units_segments (o_sec_units_segments),
        .o_display_lit        (o_display_lit),
        .o_is_running         (o_is_running),
        .o_expired            (o_expired),
        .o_minutes_now        (o_minutes_now),
        .o_seconds_now        (o_seconds_now),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    mmss_countdown_checker u_countdown_chk (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_req_valid          (i_valid),
        .i_req_stall          (o_stall),
        .i_opcode             (i_opcode),
        .i_amount             (i_amount),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_min_tens_segments  (o_min_tens_segments),
        .i_min_units_segments (o_min_units_segments),
        .i_sec_tens_segments  (o_sec_tens_segments),
        .i_sec_units_segments (o_sec_units_segments),
        .i_display_lit        (o_display_lit),
        .i_is_running         (o_is_running),
        .i_expired            (o_expired),
        .i_minutes_now        (o_minutes_now),
        .i_seconds_now        (o_seconds_now),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .pready               (pready),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .o_fail_count         (fail_count),
        .o_pending            (faces_pending)
    );

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // The receiver stalls at random, except during a requested hold-off, when it
    // keeps the result channel blocked for the whole hold-off so that the
    // block fills up and has to stall its own input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= roll(recv_idle_pct);
        end
    end

    // Offers one request, after any random gap, and returns at the edge where it
    // is taken. Valid stays high into the next call unless that call idles first,
    // so valid is never lowered and raised again within one time step.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt);
        while (roll(send_idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_amount <= amt;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Stops offering requests and waits for every expected result to come out,
    // then a few more cycles so that the pipeline is certainly empty.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (faces_pending != 0);
        repeat (5) @(posedge i_clk);
    endtask

    // One register write: a setup cycle, then an access cycle held until pready.
    task automatic cfg_write(input logic idx, input logic [PRE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(32 - PRE_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_periods(input logic [PRE_W-1:0] second_ticks,
                               input logic [PRE_W-1:0] blink_ticks);
        drain();
        cfg_write(REG_SECOND_PERIOD, second_ticks);
        cfg_write(REG_BLINK_HALF, blink_ticks);
    endtask

    // Random traffic. Most of it is a realistic session: the time is set (mostly to
    // a small value, so that countdowns finish and expire within the run), maybe
    // adjusted, the clock started, and then a run of ticks with the odd pause or
    // play mixed in. The rest is noise drawn from every opcode and amount.
    task automatic run_random(input int n_items);
        int stop_at;
        int n_ticks;
        int k;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if (roll(15)) begin
                send_req(OP_W'($urandom_range(7)), AMT_W'($urandom_range(127)));
            end else begin
                if (roll(80))
                    send_req(OP_SET, roll(85) ? AMT_W'($urandom_range(2))
                                              : AMT_W'($urandom_range(127)));
                else
                    send_req(OP_RESET, AMT_W'($urandom_range(127)));
                if (roll(30))
                    send_req(OP_ADD, roll(80) ? AMT_W'($urandom_range(1))
                                              : AMT_W'($urandom_range(127)));
                if (roll(15))
                    send_req(OP_MINUS, AMT_W'($urandom_range(127)));
                if (roll(80))
                    send_req(OP_PLAY, AMT_W'($urandom_range(127)));
                n_ticks = $urandom_range(1, 120);
                for (k = 0; k < n_ticks; k++) begin
                    if (roll(4))
                        send_req(roll(50) ? OP_PAUSE : OP_PLAY,
                                 AMT_W'($urandom_range(127)));
                    else
                        send_req(OP_TICK, AMT_W'($urandom_range(127)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_opcode <= OP_TICK;
        i_amount <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Commands under the reset periods: saturation of the minutes at both ends,
        // sets above ninety-nine that must be ignored, the unused opcode, and a
        // tick while stopped at zero.
        send_req(OP_TICK, 7'd0);
        send_req(OP_ADD, 7'd127);
        send_req(OP_ADD, 7'd1);
        send_req(OP_MINUS, 7'd0);
        send_req(OP_SET, 7'd127);
        send_req(OP_SET, 7'd100);
        send_req(OP_SET, 7'd99);
        send_req(OP_ADD, 7'd0);
        send_req(OP_NOP, 7'd127);
        send_req(OP_SET, 7'd0);
        send_req(OP_MINUS, 7'd127);
        send_req(OP_RESET, 7'd127);
        send_req(OP_PAUSE, 7'd0);

        // Shortest periods: blinking while paused with time left, the first
        // countdown step after play, and play at zero time expiring at once.
        set_periods(16'd1, 16'd1);
        send_req(OP_SET, 7'd1);
        send_req(OP_TICK, 7'd0);
        send_req(OP_TICK, 7'd127);
        send_req(OP_PLAY, 7'd0);
        send_req(OP_TICK, 7'd0);
        send_req(OP_TICK, 7'd0);
        send_req(OP_PAUSE, 7'd0);
        send_req(OP_TICK, 7'd0);
        send_req(OP_SET, 7'd0);
        send_req(OP_PLAY, 7'd0);
        send_req(OP_TICK, 7'd0);
        send_req(OP_TICK, 7'd0);

        // First phase: the sender idles now and then, the receiver most of the time.
        set_periods(PRE_W'($urandom_range(2, 5)), PRE_W'($urandom_range(1, 6)));
        send_idle_pct = 33;
        recv_idle_pct = 73;
        run_random(560);

        // Second phase: the other way round.
        set_periods(PRE_W'($urandom_range(1, 3)), PRE_W'($urandom_range(2, 8)));
        send_idle_pct = 73;
        recv_idle_pct = 33;
        run_random(560);

        // Third phase: no idling on either side, opened by a long receiver
        // hold-off while requests keep coming, so the input stall is exercised.
        set_periods(PRE_W'($urandom_range(1, 6)), PRE_W'($urandom_range(1, 6)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        run_random(580);

        drain();
        repeat (10) @(posedge i_clk);
        // Any expectation still waiting at this point counts as a failure too.
        if (fail_count == 0 && faces_pending == 0) begin
            $display("[mmss_countdown_clock_display] OK");
        end else begin
            $display("[mmss_countdown_clock_display] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[mmss_countdown_clock_display] ERROR");
        $finish;
    end

endmodule
